/* src/serial_boot_frame_loader_assert.svh */
// Assertion shorthands; clock clk, reset arst_n in the including module.
`ifndef SERIAL_BOOT_FRAME_LOADER_ASSERT_SVH
`define SERIAL_BOOT_FRAME_LOADER_ASSERT_SVH

// same-cycle implication
`define SBFL_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("sbfl assertion failed");

// next-cycle implication
`define SBFL_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("sbfl assertion failed");

`endif

/* src/sbfl_pkg.sv */
package sbfl_pkg;

	localparam int unsigned ADDR_WIDTH = 32;

	localparam logic [31:0] START_RESET = 32'h0000_0800;

	localparam logic [7:0] CHAR_NL   = 8'h0A;
	localparam logic [7:0] CHAR_SYNC = 8'h24; // '$'
	localparam logic [7:0] CHAR_ACK  = 8'h41; // 'A'
	localparam logic [7:0] CHAR_NAK  = 8'h21; // '!'
	localparam logic [7:0] CHAR_RUN  = 8'h52; // 'R'

	localparam logic [7:0] CHECK_RUN = 8'hFF;

	localparam int unsigned FRAME_STORED = 5;
	localparam logic [2:0]  POS_LAST     = 3'd5;

	typedef struct packed {
		logic        good;
		logic        run;
		logic [31:0] word;
	} frame_res_t;

endpackage

/* src/sbfl_frame_chk.sv */
module sbfl_frame_chk
	import sbfl_pkg::*;
(
	input  logic [7:0] fb [FRAME_STORED],
	input  logic [7:0] last_byte,
	output frame_res_t res
);

	// x/6 for x < 1024 as (x * 683) >> 12
	localparam logic [9:0] RECIP6 = 10'd683;

	logic [9:0]  sum;
	logic [19:0] prod;
	logic [7:0]  check;

	assign sum   = {2'b00, fb[0]} + {2'b00, fb[1]} + {2'b00, fb[2]} + {2'b00, fb[3]};
	assign prod  = sum * RECIP6;
	assign check = prod[19:12];

	assign res.word = {fb[3], fb[2], fb[1], fb[0]};
	assign res.good = (fb[4] == check) && (last_byte == CHAR_NL);
	assign res.run  = (res.word == 32'd0) && (fb[4] == CHECK_RUN);

endmodule

/* src/serial_boot_frame_loader.sv */
// Serial boot frame loader.
// Input channel: rx_valid / rx_stall carry one received serial byte (rx_byte) per beat.
// Output channel: reply_valid / reply_stall carry result beats: reply_byte to send,
// an optional memory word write (write_enable, write_address, write_data), jump_request
// and last, which marks the final beat caused by one input byte.
// start_address is loaded through start_address_we; write it only while idle.
// A byte is registered in the input stage on acceptance and decoded there; its
// first result beat is registered in the output register and shown from it.
// Throughput: one byte per cycle while the output is not stalled; the only two-beat
// case ('R' then newline) holds the input while the single output register and one pending slot send the newline.
// Bytes that cause no result pass through without occupying the output.
// Reset: waits for a sync newline, address reloads from start_address (0x800 at reset).
// A stall from the receiver holds the output beat; the input stage then fills and
// rx_stall rises, so nothing is lost or repeated.
module serial_boot_frame_loader
	import sbfl_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start_address_we,
	input  logic [31:0] start_address,
	input  logic        rx_valid,
	output logic        rx_stall,
	input  logic [7:0]  rx_byte,
	output logic        reply_valid,
	input  logic        reply_stall,
	output logic [7:0]  reply_byte,
	output logic        write_enable,
	output logic [31:0] write_address,
	output logic [31:0] write_data,
	output logic        jump_request,
	output logic        last
);

`include "serial_boot_frame_loader_assert.svh"

	typedef enum logic [1:0] {
		PH_SYNC = 2'd0,
		PH_LOAD = 2'd1,
		PH_DONE = 2'd2
	} phase_t;

	// config
	logic [31:0] start_q;

	// input stage
	logic       rx_valid_s1;
	logic [7:0] rx_byte_s1;

	// decode state
	phase_t                phase_q, phase_n;
	logic [2:0]            pos_q, pos_n;
	logic [ADDR_WIDTH-1:0] addr_q, addr_n;
	logic [7:0]            fb_q [FRAME_STORED];

	// output register and second-beat slot
	logic        out_valid_q;
	logic [7:0]  reply_q;
	logic        we_q;
	logic [31:0] waddr_q;
	logic [31:0] wdata_q;
	logic        jump_q;
	logic        last_q;
	logic        pend_q;

	frame_res_t chk;

	// result of decoding the byte in s1
	logic        has_res;
	logic        res_pend;
	logic [7:0]  res_reply;
	logic        res_we;
	logic [31:0] res_addr;
	logic [31:0] res_data;
	logic        res_last;
	logic        fb_we;

	logic can_take;
	logic adv;

	sbfl_frame_chk u_chk (
		.fb        (fb_q),
		.last_byte (rx_byte_s1),
		.res       (chk)
	);

	// output slot frees when empty or taken this cycle; the pending newline goes first
	assign can_take = !out_valid_q || !reply_stall;
	assign adv      = rx_valid_s1 && !pend_q && can_take;
	assign rx_stall = rx_valid_s1 && !adv;

	always_comb begin
		phase_n   = phase_q;
		pos_n     = pos_q;
		addr_n    = addr_q;
		has_res   = 1'b0;
		res_pend  = 1'b0;
		res_reply = CHAR_NAK;
		res_we    = 1'b0;
		res_addr  = 32'd0;
		res_data  = 32'd0;
		res_last  = 1'b1;
		fb_we     = 1'b0;
		unique case (phase_q)
			PH_SYNC: begin
				if (rx_byte_s1 == CHAR_NL) begin
					phase_n   = PH_LOAD;
					pos_n     = 3'd0;
					addr_n    = start_q[ADDR_WIDTH-1:0];
					has_res   = 1'b1;
					res_reply = CHAR_SYNC;
				end
			end
			PH_LOAD: begin
				if (pos_q != POS_LAST) begin
					fb_we = 1'b1;
					pos_n = pos_q + 3'd1;
				end else begin
					pos_n   = 3'd0;
					has_res = 1'b1;
					priority if (chk.good) begin
						res_reply = CHAR_ACK;
						res_we    = 1'b1;
						res_addr  = 32'(addr_q);
						res_data  = chk.word;
						addr_n    = addr_q + ADDR_WIDTH'(4);
					end else if (chk.run) begin
						res_reply = CHAR_RUN;
						res_last  = 1'b0;
						res_pend  = 1'b1;
						phase_n   = PH_DONE;
					end else begin
						res_reply = CHAR_NAK;
					end
				end
			end
			default: begin
				// finished (and the unused code): bytes are dropped
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q <= START_RESET;
		end else if (start_address_we) begin
			start_q <= start_address;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rx_valid_s1 <= 1'b0;
		end else if (!rx_stall) begin
			rx_valid_s1 <= rx_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rx_valid && !rx_stall) begin
			rx_byte_s1 <= rx_byte;
		end
		if (adv && fb_we) begin
			fb_q[pos_q] <= rx_byte_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_SYNC;
			pos_q       <= 3'd0;
			addr_q      <= START_RESET[ADDR_WIDTH-1:0];
			out_valid_q <= 1'b0;
			reply_q     <= 8'd0;
			we_q        <= 1'b0;
			waddr_q     <= 32'd0;
			wdata_q     <= 32'd0;
			jump_q      <= 1'b0;
			last_q      <= 1'b0;
			pend_q      <= 1'b0;
		end else begin
			if (adv) begin
				phase_q <= phase_n;
				pos_q   <= pos_n;
				addr_q  <= addr_n;
			end
			if (can_take) begin
				priority if (pend_q) begin
					out_valid_q <= 1'b1;
					reply_q     <= CHAR_NL;
					we_q        <= 1'b0;
					waddr_q     <= 32'd0;
					wdata_q     <= 32'd0;
					jump_q      <= 1'b1;
					last_q      <= 1'b1;
					pend_q      <= 1'b0;
				end else if (adv && has_res) begin
					out_valid_q <= 1'b1;
					reply_q     <= res_reply;
					we_q        <= res_we;
					waddr_q     <= res_addr;
					wdata_q     <= res_data;
					jump_q      <= 1'b0;
					last_q      <= res_last;
					pend_q      <= res_pend;
				end else begin
					out_valid_q <= 1'b0;
				end
			end
		end
	end

	assign reply_valid   = out_valid_q;
	assign reply_byte    = reply_q;
	assign write_enable  = we_q;
	assign write_address = waddr_q;
	assign write_data    = wdata_q;
	assign jump_request  = jump_q;
	assign last          = last_q;

	`SBFL_ASSERT_NOW(a_pend_behind_out, pend_q, out_valid_q)
	`SBFL_ASSERT_NOW(a_run_has_pend, out_valid_q && (reply_q == CHAR_RUN), pend_q && !last_q)
	`SBFL_ASSERT_NOW(a_jump_is_nl, out_valid_q && jump_q, (reply_q == CHAR_NL) && last_q)
	`SBFL_ASSERT_NOW(a_write_is_ack, out_valid_q && we_q, reply_q == CHAR_ACK)
	`SBFL_ASSERT_NEXT(a_done_stays, phase_q == PH_DONE, phase_q == PH_DONE)

endmodule

/* dv/sbfl_reply_checker.sv */
module sbfl_reply_checker
	import sbfl_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start_address_we,
	input  logic [31:0] start_address,
	input  logic        rx_valid,
	input  logic        rx_stall,
	input  logic [7:0]  rx_byte,
	input  logic        reply_valid,
	input  logic        reply_stall,
	input  logic [7:0]  reply_byte,
	input  logic        write_enable,
	input  logic [31:0] write_address,
	input  logic [31:0] write_data,
	input  logic        jump_request,
	input  logic        last,
	output int          fail_count,
	output int          replies_due
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned CHECK_DIVISOR = 6;

	typedef enum logic [1:0] {LOAD_SYNC, LOAD_FRAMES, LOAD_DONE} load_phase_t;

	typedef struct packed {
		logic [7:0]  reply;
		logic        we;
		logic [31:0] addr;
		logic [31:0] data;
		logic        jump;
		logic        final_beat;
	} reply_beat_t;

	reply_beat_t           due_beats[$];
	load_phase_t           load_phase;
	logic [2:0]            frame_pos;
	logic [7:0]            frame_buf[FRAME_STORED];
	logic [ADDR_WIDTH-1:0] load_addr;
	logic [31:0]           start_reg;

	initial fail_count = 0;

	task automatic push_beat(input logic [7:0] r, input logic we, input logic [31:0] a,
			input logic [31:0] d, input logic j, input logic l);
		reply_beat_t beat;
		beat = '{reply: r, we: we, addr: a, data: d, jump: j, final_beat: l};
		due_beats.push_back(beat);
	endtask

	// one received byte through the loader's state
	task automatic decode_byte(input logic [7:0] b);
		logic [9:0]  sum;
		logic [7:0]  chk;
		logic [31:0] word;
		case (load_phase)
			LOAD_SYNC: begin
				if (b == CHAR_NL) begin
					load_phase = LOAD_FRAMES;
					frame_pos  = '0;
					load_addr  = start_reg[ADDR_WIDTH-1:0];
					push_beat(CHAR_SYNC, 1'b0, '0, '0, 1'b0, 1'b1);
				end
			end
			LOAD_FRAMES: begin
				if (frame_pos < POS_LAST) begin
					frame_buf[frame_pos] = b;
					frame_pos++;
				end else begin
					frame_pos = '0;
					word = {frame_buf[3], frame_buf[2], frame_buf[1], frame_buf[0]};
					sum  = 10'(frame_buf[0]) + 10'(frame_buf[1]) + 10'(frame_buf[2])
						+ 10'(frame_buf[3]);
					chk  = 8'(sum / CHECK_DIVISOR);
					if (frame_buf[4] == chk && b == CHAR_NL) begin
						push_beat(CHAR_ACK, 1'b1, 32'(load_addr), word, 1'b0, 1'b1);
						load_addr = load_addr + 1'b1 + 2'd3;
					end else if (word == '0 && frame_buf[4] == CHECK_RUN) begin
						push_beat(CHAR_RUN, 1'b0, '0, '0, 1'b0, 1'b0);
						push_beat(CHAR_NL, 1'b0, '0, '0, 1'b1, 1'b1);
						load_phase = LOAD_DONE;
					end else begin
						push_beat(CHAR_NAK, 1'b0, '0, '0, 1'b0, 1'b1);
					end
				end
			end
			default: ;
		endcase
	endtask

	task automatic check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch: expected %h, got %h", $time, name, want, got);
			fail_count++;
		end
	endtask

	task automatic check_beat();
		reply_beat_t want;
		if (due_beats.size() == 0) begin
			$display("%0t: reply beat with none due: expected nothing, got reply_byte %h",
				$time, reply_byte);
			fail_count++;
		end else begin
			want = due_beats.pop_front();
			check_field("reply_byte", 32'(want.reply), 32'(reply_byte));
			check_field("write_enable", 32'(want.we), 32'(write_enable));
			check_field("write_address", want.addr, write_address);
			check_field("write_data", want.data, write_data);
			check_field("jump_request", 32'(want.jump), 32'(jump_request));
			check_field("last", 32'(want.final_beat), 32'(last));
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			load_phase = LOAD_SYNC;
			frame_pos  = '0;
			start_reg  = START_RESET;
			load_addr  = START_RESET[ADDR_WIDTH-1:0];
			foreach (frame_buf[i]) frame_buf[i] = '0;
			due_beats.delete();
		end else begin
			// compare first: a beat leaving now was caused by an earlier byte
			if (reply_valid && !reply_stall) check_beat();
			if (start_address_we) start_reg = start_address;
			if (rx_valid && !rx_stall) decode_byte(rx_byte);
		end
		replies_due = due_beats.size();
	end

endmodule

/* dv/tb_serial_boot_frame_loader.sv */
module tb_serial_boot_frame_loader
	import sbfl_pkg::*;
();
	timeunit 1ns;
	timeprecision 1ps;

	// cycles to let a byte that causes no reply clear the pipe
	localparam int SETTLE_CYCLES = 6;
	// length of the long receiver hold-off, long enough to back up the input
	localparam int HOLD_CYCLES   = 300;
	localparam int FRAMES_PER_PHASE = 40;
	localparam int CHECK_DIVISOR = 6;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start_address_we = 1'b0;
	logic [31:0] start_address = '0;
	logic        rx_valid = 1'b0;
	logic [7:0]  rx_byte = '0;
	logic        reply_stall = 1'b0;
	wire         rx_stall;
	wire         reply_valid;
	wire  [7:0]  reply_byte;
	wire         write_enable;
	wire  [31:0] write_address;
	wire  [31:0] write_data;
	wire         jump_request;
	wire         last;

	int   fail_count;
	int   replies_due;
	int   send_idle_pct = 0;  // only read by the stimulus process
	int   stall_pct = 0;      // read by the receiver, so updated on the edge
	logic long_hold = 1'b0;

	serial_boot_frame_loader i_dut (.*);

	// watches both channels, predicts every reply beat and compares
	sbfl_reply_checker i_checker (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// receiver: random stalls, plus the long hold-off when asked for
	always @(posedge clk)
		reply_stall <= long_hold || ($urandom_range(99) < stall_pct);

	// one byte beat; random idle cycles first, then hold until accepted
	task automatic put_byte(input logic [7:0] b);
		while ($urandom_range(99) < send_idle_pct) begin
			rx_valid <= 1'b0;
			@(posedge clk);
		end
		rx_valid <= 1'b1;
		rx_byte  <= b;
		do @(posedge clk); while (rx_stall);
	endtask

	task automatic put_frame(input logic [31:0] word, input logic [7:0] chk,
			input logic [7:0] tail);
		for (int i = 0; i < 4; i++) put_byte(word[8*i +: 8]);
		put_byte(chk);
		put_byte(tail);
	endtask

	// check byte that makes a frame good: byte sum over six, truncated
	function automatic logic [7:0] good_check(input logic [31:0] word);
		int sum;
		sum = int'(word[7:0]) + int'(word[15:8]) + int'(word[23:16]) + int'(word[31:24]);
		return 8'(sum / CHECK_DIVISOR);
	endfunction

	// mostly good frames with random words; the rest bad check, bad terminator
	// or plain noise. A zero word with check 0xFF would end the load, so it is
	// steered away from here and sent only once at the very end.
	task automatic random_frame();
		logic [31:0] word;
		logic [7:0]  chk;
		logic [7:0]  tail;
		int          kind;
		kind = $urandom_range(99);
		case ($urandom_range(7))
			0: word = '0;
			1: word = '1;
			default: word = $urandom;
		endcase
		chk  = good_check(word);
		tail = CHAR_NL;
		if (kind < 12) begin
			chk = chk ^ 8'($urandom_range(255, 1));
		end else if (kind < 22) begin
			tail = 8'($urandom);
			if (tail == CHAR_NL) tail = ~tail;
		end else if (kind < 30) begin
			chk  = 8'($urandom);
			tail = 8'($urandom);
		end
		if (word == '0 && chk == CHECK_RUN) chk = 8'h00;
		put_frame(word, chk, tail);
	endtask

	// stop sending and wait until every predicted reply has been seen,
	// then let any byte that causes no reply drain out of the pipe
	task automatic wait_drained();
		rx_valid <= 1'b0;
		do @(posedge clk); while (replies_due != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_start(input logic [31:0] value);
		start_address_we <= 1'b1;
		start_address    <= value;
		@(posedge clk);
		start_address_we <= 1'b0;
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Before sync: bytes are dropped, and the start address is only
		// latched when the sync newline arrives, so the last write counts.
		write_start(32'h0000_0000);
		put_byte(8'h00);
		wait_drained();
		write_start($urandom);
		put_byte(8'hFF);
		wait_drained();
		// top of the address space: the second word wraps round to 0x3
		write_start(32'hFFFF_FFFF);
		put_byte(8'h0D);
		put_byte(CHAR_NL);

		// directed frames: zero word, all-ones word, bad check with bad tail
		put_frame(32'h0000_0000, good_check(32'h0000_0000), CHAR_NL);
		put_frame(32'hFFFF_FFFF, good_check(32'hFFFF_FFFF), CHAR_NL);
		put_frame(32'h1234_5678, good_check(32'h1234_5678) ^ 8'h01, 8'h0D);
		wait_drained();
		// the loader is past sync now, so this must not move the address
		write_start(START_RESET);

		// random frames under four idling mixes; pause for a full drain after each
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin send_idle_pct = 0;  stall_pct <= 0;  end
				1: begin send_idle_pct = 55; stall_pct <= 0;  end
				2: begin send_idle_pct = 0;  stall_pct <= 55; end
				default: begin send_idle_pct = 26; stall_pct <= 26; end
			endcase
			repeat (FRAMES_PER_PHASE) random_frame();
			wait_drained();
			write_start($urandom);
		end

		// long receiver hold-off while the sender keeps going flat out,
		// so the output backs up and the block pushes back on rx
		send_idle_pct = 0;
		stall_pct <= 0;
		fork
			begin
				long_hold <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				long_hold <= 1'b0;
			end
		join_none
		repeat (30) random_frame();
		wait_drained();

		// run frame: zero word with check 0xFF gives 'R', newline and the jump;
		// every byte afterwards, newline included, is ignored
		send_idle_pct = 26;
		stall_pct <= 26;
		put_frame(32'h0000_0000, CHECK_RUN, $urandom_range(1) ? CHAR_NL : 8'($urandom));
		put_byte(CHAR_NL);
		repeat (11) put_byte(8'($urandom));
		wait_drained();

		if (fail_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

	// hard stop well beyond the slowest correct run
	initial begin
		#2_000_000;
		$display("simulation failed");
		$finish;
	end

endmodule

/* sim.f */
+incdir+src
src/sbfl_pkg.sv
src/sbfl_frame_chk.sv
src/serial_boot_frame_loader.sv
dv/sbfl_reply_checker.sv
dv/tb_serial_boot_frame_loader.sv
